>>> rtl/fufd_pkg.sv
// ----------------------------------------------------------------------------
// fufd_pkg
// Shared types, constants and helpers of the form field decoder.
// ----------------------------------------------------------------------------
package fufd_pkg;

  localparam int LEN_W       = 24;
  localparam int FLEN_W      = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_BODY_LEN      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FIELD_LEN = CFG_INDEX_W'(1);

  localparam logic [LEN_W-1:0]  BODY_LEN_RST      = '0;
  localparam logic [FLEN_W-1:0] MAX_FIELD_LEN_RST = FLEN_W'(999);

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_TERM,
    CLS_PLUS,
    CLS_PCT
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic [3:0] hex;
    logic       hex_ok;
    logic       done;
  } fufd_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       field_is_value;
    logic       bad_hex;
    logic       form_done;
  } fufd_result_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

>>> rtl/form_urlencoded_field_decoder_core.sv
// ----------------------------------------------------------------------------
// form_urlencoded_field_decoder_core
// Decodes a form-urlencoded body into field bytes with field marks.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          in_byte
//  result    pop / empty          out_byte, byte_valid, field_end,
//                                 field_is_value, bad_hex, form_done
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One byte per cycle sustained while full is low and pop keeps up; each
//  body byte moves through a 4-word queue, then the result register.
//  full follows the queue; the result register reloads in the cycle it pops.
//  rst is synchronous: counters, escape state, config and res_valid reset.
// ----------------------------------------------------------------------------
module form_urlencoded_field_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             byte_valid,
  output logic                             field_end,
  output logic                             field_is_value,
  output logic                             bad_hex,
  output logic                             form_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fufd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fufd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fufd_pkg::*;

  logic [LEN_W-1:0]  body_len;
  logic [FLEN_W-1:0] max_field_len;
  logic              q_wr, q_rd, q_full, q_empty;
  fufd_word_t        q_wdata, q_rdata;
  fufd_result_t      res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_len      <= BODY_LEN_RST;
      max_field_len <= MAX_FIELD_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BODY_LEN:      body_len      <= cfg_data[LEN_W-1:0];
        REG_MAX_FIELD_LEN: max_field_len <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  fufd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .body_len (body_len),
    .push     (push),
    .in_byte  (in_byte),
    .full     (full),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  fufd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  fufd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_field_len (max_field_len),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .res           (res)
  );

  assign out_byte       = res.out_byte;
  assign byte_valid     = res.byte_valid;
  assign field_end      = res.field_end;
  assign field_is_value = res.field_is_value;
  assign bad_hex        = res.bad_hex;
  assign form_done      = res.form_done;

endmodule

>>> rtl/fufd_queue.sv
// ----------------------------------------------------------------------------
// fufd_queue
// Short word queue between the classifying front and the decoding back.
// ----------------------------------------------------------------------------
module fufd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  fufd_pkg::fufd_word_t wdata,
  output logic               full,
  input  logic               rd,
  output fufd_pkg::fufd_word_t rdata,
  output logic               empty
);
  import fufd_pkg::*;

  fufd_word_t         mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/fufd_front.sv
// ----------------------------------------------------------------------------
// fufd_front
// Counts body bytes, drops bytes past the body and classifies each byte.
// ----------------------------------------------------------------------------
module fufd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fufd_pkg::LEN_W-1:0]  body_len,
  input  logic                        push,
  input  logic [7:0]                  in_byte,
  output logic                        full,
  output logic                        q_wr,
  output fufd_pkg::fufd_word_t        q_wdata,
  input  logic                        q_full
);
  import fufd_pkg::*;

  logic [LEN_W-1:0] bytes_seen;
  logic [LEN_W-1:0] bytes_seen_next;
  logic             live;
  logic             accept;
  logic [4:0]       hx;

  assign full            = q_full;
  assign accept          = push && !q_full;
  assign live            = bytes_seen < body_len;
  assign bytes_seen_next = bytes_seen + LEN_W'(1);
  assign q_wr            = accept && live;
  assign hx              = hex_decode(in_byte);

  always_comb begin
    q_wdata.data   = in_byte;
    q_wdata.hex    = hx[3:0];
    q_wdata.hex_ok = hx[4];
    q_wdata.done   = (bytes_seen_next == body_len);
    if (in_byte == CH_EQ || in_byte == CH_AMP || in_byte == CH_NUL) q_wdata.cls = CLS_TERM;
    else if (in_byte == CH_PLUS) q_wdata.cls = CLS_PLUS;
    else if (in_byte == CH_PCT)  q_wdata.cls = CLS_PCT;
    else q_wdata.cls = CLS_OTHER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (q_wr) begin
      bytes_seen <= bytes_seen_next;
    end
  end

endmodule

>>> rtl/fufd_back.sv
// ----------------------------------------------------------------------------
// fufd_back
// Runs the escape and field state per word and holds the result register.
// ----------------------------------------------------------------------------
module fufd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fufd_pkg::FLEN_W-1:0] max_field_len,
  input  logic                        q_empty,
  input  fufd_pkg::fufd_word_t        q_rdata,
  output logic                        q_rd,
  output logic                        empty,
  input  logic                        pop,
  output fufd_pkg::fufd_result_t      res
);
  import fufd_pkg::*;

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t           phase, phase_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             escape_bad, escape_bad_next;
  logic [FLEN_W-1:0] field_count, field_count_next;
  logic             in_value, in_value_next;
  logic             res_valid;
  fufd_result_t     res_next;

  assign empty = !res_valid;
  assign q_rd  = !q_empty && (!res_valid || pop);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    escape_bad_next  = escape_bad;
    field_count_next = field_count;
    in_value_next    = in_value;
    res_next         = '0;
    res_next.field_is_value = in_value;
    res_next.form_done      = q_rdata.done;
    case (phase)
      PH_HIGH: begin
        high_nibble_next = q_rdata.hex;
        escape_bad_next  = !q_rdata.hex_ok;
        phase_next       = PH_LOW;
      end
      PH_LOW: begin
        res_next.out_byte   = {high_nibble, q_rdata.hex};
        res_next.bad_hex    = escape_bad || !q_rdata.hex_ok;
        res_next.byte_valid = 1'b1;
        field_count_next    = field_count + FLEN_W'(1);
        phase_next          = PH_PLAIN;
        high_nibble_next    = '0;
        escape_bad_next     = 1'b0;
      end
      default: begin
        if (q_rdata.cls == CLS_TERM) begin
          res_next.field_end = 1'b1;
        end else if (field_count < max_field_len) begin
          if (q_rdata.cls == CLS_PCT) begin
            phase_next = PH_HIGH;
          end else begin
            res_next.out_byte   = (q_rdata.cls == CLS_PLUS) ? CH_SPACE : q_rdata.data;
            res_next.byte_valid = 1'b1;
            field_count_next    = field_count + FLEN_W'(1);
          end
        end
      end
    endcase
    if (q_rdata.done) res_next.field_end = 1'b1;
    if (res_next.field_end) begin
      phase_next       = PH_PLAIN;
      high_nibble_next = '0;
      escape_bad_next  = 1'b0;
      field_count_next = '0;
      in_value_next    = !in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PLAIN;
      high_nibble <= '0;
      escape_bad  <= 1'b0;
      field_count <= '0;
      in_value    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (q_rd) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        escape_bad  <= escape_bad_next;
        field_count <= field_count_next;
        in_value    <= in_value_next;
        res_valid   <= 1'b1;
      end else if (pop) begin
        res_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/fufd_checker.sv
// ----------------------------------------------------------------------------
// fufd_checker
// Port-level checks of the form field decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fufd_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       field_end,
  input logic       field_is_value,
  input logic       bad_hex,
  input logic       form_done
);

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(field_end)
                          && $stable(field_is_value) && $stable(form_done)))
    else $error("result word changed while stalled");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (out_byte == 8'h00 && !bad_hex))
    else $error("dropped byte carries data or bad_hex");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && form_done) |-> field_end)
    else $error("form_done without field_end");

  a_kind_toggle: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && field_end) ##1 (!empty && !$past(rst))
      |-> (field_is_value != $past(field_is_value)))
    else $error("field kind did not toggle after field end");

endmodule

bind form_urlencoded_field_decoder_core fufd_checker u_fufd_checker (.*);
